// ===== rtl/gcph_pkg.sv =====
// ----------------------------------------------------------------------------
// gcph_pkg
// shared types and constants of the gathered cost polynomial hash
// ----------------------------------------------------------------------------
package gcph_pkg;

   localparam int unsigned TABLE_DEPTH_DEF = 4096;

   // field widths of the request and response words
   localparam int unsigned IDX_W   = 12;
   localparam int unsigned REC_W   = 32;
   localparam int unsigned COST_W  = 35;
   localparam int unsigned HASH_W  = 64;
   localparam int unsigned HALF_W  = 32;
   localparam int unsigned MULT_W  = 31;
   localparam int unsigned PLO_W   = HALF_W + MULT_W;
   localparam int unsigned REQ_D_W = 144;

   localparam logic [MULT_W-1:0] HASH_MULT = 31'd1315423911;

   // operation codes carried in tuser
   typedef enum logic {
      FUNC_LOAD   = 1'b0,
      FUNC_ACCESS = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM
   } state_type;

   // controls from the sequencer to the hash datapath
   typedef struct packed {
      logic mul_en;
      logic sum_en;
      logic restart;
   } hash_ctl_type;

endpackage

// ===== rtl/gcph_cost_table.sv =====
// ----------------------------------------------------------------------------
// gcph_cost_table
// cost computation and the synchronous cost memory
// ----------------------------------------------------------------------------
module gcph_cost_table
   import gcph_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  index,
   input  logic [REC_W-1:0]  rec_base,
   input  logic [REC_W-1:0]  rec_retry,
   input  logic [REC_W-1:0]  rec_miss,
   input  logic [REC_W-1:0]  byte_count,
   output logic [COST_W-1:0] cost
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = ((AW > IDX_W) ? AW : IDX_W) + 1;

   logic [COST_W-1:0] mem [TABLE_DEPTH];
   logic [COST_W-1:0] rdata_ff;
   logic              in_range_ff;
   logic [CW-1:0]     index_wide;
   logic [AW-1:0]     addr;
   logic              in_range;
   logic [COST_W-1:0] new_cost;

   assign index_wide = CW'(index);
   assign addr       = index_wide[AW-1:0];
   assign in_range   = (index_wide < CW'(TABLE_DEPTH));

   // base + 2*retry + miss + bytes/16, never beyond 35 bits
   assign new_cost = COST_W'(rec_base)
                   + {COST_W'(rec_retry) << 1}
                   + COST_W'(rec_miss)
                   + COST_W'(byte_count[REC_W-1:4]);

   always_ff @(posedge clock) begin
      if (wr_en && in_range) begin
         mem[addr] <= new_cost;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff    <= mem[addr];
         in_range_ff <= in_range;
      end
   end

   // an index beyond the table folds a cost of zero
   assign cost = in_range_ff ? rdata_ff : '0;

endmodule

// ===== rtl/gcph_hash_unit.sv =====
// ----------------------------------------------------------------------------
// gcph_hash_unit
// running hash, multiply split in two 32-bit halves then summed
// ----------------------------------------------------------------------------
module gcph_hash_unit
   import gcph_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  hash_ctl_type      ctl,
   input  logic [COST_W-1:0] cost,
   output logic [HASH_W-1:0] hash
);

   logic [HASH_W-1:0] hash_ff, hash_in;
   logic [PLO_W-1:0]  prod_lo_ff;
   logic [HALF_W-1:0] prod_hi_ff;
   logic [COST_W-1:0] cost_ff;
   logic [HASH_W-1:0] src;
   logic [PLO_W-1:0]  mul_lo;
   logic [HALF_W-1:0] mul_hi;

   assign src    = ctl.restart ? '0 : hash_ff;
   assign mul_lo = PLO_W'(src[HALF_W-1:0]) * PLO_W'(HASH_MULT);
   // only the low half of the upper product survives modulo 2^64
   assign mul_hi = src[HASH_W-1:HALF_W] * HALF_W'(HASH_MULT);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_lo_ff <= mul_lo;
         prod_hi_ff <= mul_hi;
         cost_ff    <= cost;
      end
   end

   // high partial product only counts in the upper half
   assign hash_in = HASH_W'(prod_lo_ff)
                  + {prod_hi_ff, {HALF_W{1'b0}}}
                  + HASH_W'(cost_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
      end else if (ctl.sum_en) begin
         hash_ff <= hash_in;
      end
   end

   assign hash = hash_ff;

endmodule

// ===== rtl/gathered_cost_polynomial_hash_top.sv =====
// ----------------------------------------------------------------------------
// gathered_cost_polynomial_hash_top
// cost table with a 64-bit polynomial hash over gathered costs
// ----------------------------------------------------------------------------
// usage
//   req channel: tuser selects a load word (writes one table entry with
//   base + 2*retry + miss + bytes/16) or an access word (reads an entry and
//   folds it into hash = hash*1315423911 + cost, modulo 2^64, from zero on restart)
//   rsp channel: one word per access carrying the running hash, none for loads
// sequencing
//   a load leaves the block idle and ready for the next word
//   an access is done in steps: memory read, the partial products of the
//   two 32-bit halves of the hash multiply, then the final add into the
//   hash register; no new word is taken until that add has been made
//   a result appears on rsp as the add writes the hash register
// reset
//   clears the running hash and the control state; the table is not cleared
//   and an entry must be loaded before it is accessed
// stall
//   a waiting result does not block new words; an access holds at its final
//   add until the previous result has been taken
// ----------------------------------------------------------------------------
module gathered_cost_polynomial_hash_top
   import gcph_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // entry_index, base, retry, miss, byte_count, restart
   input  logic [REQ_D_W-1:0] req_tdata,
   // func
   input  logic               req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // running_hash
   output logic [HASH_W-1:0]  rsp_tdata
);

   state_type         state_ff, state_in;
   logic              restart_ff, restart_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_fire;
   logic              is_access;
   hash_ctl_type      ctl;
   logic [COST_W-1:0] cost;

   // request word unpacking
   logic [IDX_W-1:0] entry_index;
   logic [REC_W-1:0] rec_base, rec_retry, rec_miss, byte_count;
   logic             restart;

   assign entry_index = req_tdata[11:0];
   assign rec_base    = req_tdata[43:12];
   assign rec_retry   = req_tdata[75:44];
   assign rec_miss    = req_tdata[107:76];
   assign byte_count  = req_tdata[139:108];
   assign restart     = req_tdata[140];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign is_access  = (func_type'(req_tuser) == FUNC_ACCESS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         restart_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         restart_ff   <= restart_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      restart_in   = restart_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctl.mul_en   = 1'b0;
      ctl.sum_en   = 1'b0;
      ctl.restart  = restart_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_access) begin
               restart_in = restart;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            ctl.mul_en = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            // hash register doubles as the output register
            if (!rsp_valid_ff || rsp_tready) begin
               ctl.sum_en   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   gcph_cost_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock      (clock),
      .wr_en      (req_fire && !is_access),
      .rd_en      (req_fire && is_access),
      .index      (entry_index),
      .rec_base   (rec_base),
      .rec_retry  (rec_retry),
      .rec_miss   (rec_miss),
      .byte_count (byte_count),
      .cost       (cost)
   );

   gcph_hash_unit u_hash (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .cost  (cost),
      .hash  (rsp_tdata)
   );

   assign rsp_tvalid = rsp_valid_ff;

endmodule
